// ===== rtl/assert_macros.svh =====
// Assertion macros used by the modular inverse core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== rtl/mi_pkg.sv =====
// Package with widths and cell payload types of the modular inverse core.
package mi_pkg;
	localparam int WIDTH = 16;
	localparam int CW = WIDTH + 3;
	localparam int NDIV = WIDTH;
	localparam int NGCD = 4 * WIDTH + 2;

	typedef struct packed {
		logic [WIDTH-1:0] r;
		logic [WIDTH-1:0] x;
		logic [WIDTH-1:0] n;
	} div_t;

	typedef struct packed {
		logic [WIDTH-1:0] u;
		logic [WIDTH-1:0] v;
		logic signed [CW-1:0] ca;
		logic signed [CW-1:0] cb;
		logic signed [CW-1:0] cc;
		logic signed [CW-1:0] cd;
		logic [WIDTH-1:0] x;
		logic [WIDTH-1:0] n;
	} gcd_t;
endpackage

// ===== rtl/mi_div_cell.sv =====
// One restoring-division cell: brings in one bit of the value and reduces modulo n.
module mi_div_cell import mi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  div_t in_d,
	output logic out_vld,
	output div_t out_d
);
	logic [WIDTH:0] t;
	logic [WIDTH:0] t_sub;
	div_t nxt;
	logic vld_q;
	div_t d_q;

	always_comb begin
		t = {in_d.r, in_d.x[WIDTH-1]};
		t_sub = t - {1'b0, in_d.n};
		nxt.n = in_d.n;
		nxt.x = {in_d.x[WIDTH-2:0], 1'b0};
		if (t >= {1'b0, in_d.n}) begin
			nxt.r = t_sub[WIDTH-1:0];
		end else begin
			nxt.r = t[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign out_vld = vld_q;
	assign out_d = d_q;
endmodule

// ===== rtl/mi_gcd_cell.sv =====
// One binary extended GCD cell: a single halving or subtraction step.
module mi_gcd_cell import mi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  gcd_t in_d,
	output logic out_vld,
	output gcd_t out_d
);
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] s1;
	logic signed [CW-1:0] s2;
	gcd_t nxt;
	logic vld_q;
	gcd_t d_q;

	always_comb begin
		xs = $signed({{(CW-WIDTH){1'b0}}, in_d.x});
		ys = $signed({{(CW-WIDTH){1'b0}}, in_d.n});
		nxt = in_d;
		s1 = '0;
		s2 = '0;
		if (in_d.u != '0) begin
			if (!in_d.u[0]) begin
				nxt.u = in_d.u >> 1;
				if (!in_d.ca[0] && !in_d.cb[0]) begin
					s1 = in_d.ca;
					s2 = in_d.cb;
				end else begin
					s1 = in_d.ca + ys;
					s2 = in_d.cb - xs;
				end
				nxt.ca = s1 >>> 1;
				nxt.cb = s2 >>> 1;
			end else if (!in_d.v[0]) begin
				nxt.v = in_d.v >> 1;
				if (!in_d.cc[0] && !in_d.cd[0]) begin
					s1 = in_d.cc;
					s2 = in_d.cd;
				end else begin
					s1 = in_d.cc + ys;
					s2 = in_d.cd - xs;
				end
				nxt.cc = s1 >>> 1;
				nxt.cd = s2 >>> 1;
			end else if (in_d.u >= in_d.v) begin
				nxt.u = in_d.u - in_d.v;
				nxt.ca = in_d.ca - in_d.cc;
				nxt.cb = in_d.cb - in_d.cd;
			end else begin
				nxt.v = in_d.v - in_d.u;
				nxt.cc = in_d.cc - in_d.ca;
				nxt.cd = in_d.cd - in_d.cb;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign out_vld = vld_q;
	assign out_d = d_q;
endmodule

// ===== rtl/modular_inverse_core.sv =====
// Top level of the modular inverse core: cell chains and output register.
//
// Write the modulus through modulus / modulus_valid / modulus_ready; the port
// is always ready and the register holds 1 after reset. Write it only while
// no beat is in flight. Each value beat (value, value_valid, value_stall)
// gives one result beat (inverse, not_unit, result_valid, result_stall).
// A value first passes WIDTH division cells that reduce it modulo the
// modulus, then 4*WIDTH+2 binary extended GCD cells, one step each, then the
// output register. The chain is a pipeline, so one beat can enter every
// cycle while value_stall is low. When result_stall is
// high while a result waits, the whole chain freezes and value_stall rises.
// Reset clears all valid bits and sets the modulus to 1. A value that shares
// a factor with the modulus gives not_unit 1 and inverse 0; modulus 1 gives
// inverse 1.
`include "assert_macros.svh"
module modular_inverse_core import mi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic modulus_valid,
	output logic modulus_ready,
	input  logic [WIDTH-1:0] modulus,
	input  logic value_valid,
	output logic value_stall,
	input  logic [WIDTH-1:0] value,
	output logic result_valid,
	input  logic result_stall,
	output logic [WIDTH-1:0] inverse,
	output logic not_unit
);
	logic [WIDTH-1:0] modulus_q;
	logic adv;
	logic div_vld [NDIV+1];
	div_t div_d [NDIV+1];
	logic gcd_vld [NGCD+1];
	gcd_t gcd_d [NGCD+1];
	logic out_vld_q;
	logic [WIDTH-1:0] inv_q;
	logic bad_q;
	logic [WIDTH-1:0] n_out_q;
	gcd_t fin;
	logic signed [CW-1:0] ns;
	logic signed [CW-1:0] t1;
	logic signed [CW-1:0] t2;
	logic signed [CW-1:0] t3;
	logic signed [CW-1:0] t4;
	logic [WIDTH-1:0] inv_nxt;
	logic bad_nxt;

	assign modulus_ready = 1'b1;
	assign adv = !out_vld_q || !result_stall;
	assign value_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= {{(WIDTH-1){1'b0}}, 1'b1};
		end else if (modulus_valid && modulus_ready) begin
			modulus_q <= modulus;
		end
	end

	assign div_vld[0] = value_valid;
	assign div_d[0] = '{r: '0, x: value, n: modulus_q};

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		mi_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_vld(div_vld[i]), .in_d(div_d[i]),
			.out_vld(div_vld[i+1]), .out_d(div_d[i+1])
		);
	end

	// The reduced value starts the GCD chain with the identity coefficients.
	assign gcd_vld[0] = div_vld[NDIV];
	assign gcd_d[0] = '{u: div_d[NDIV].r, v: div_d[NDIV].n,
		ca: CW'(1), cb: '0, cc: '0, cd: CW'(1),
		x: div_d[NDIV].r, n: div_d[NDIV].n};

	for (genvar i = 0; i < NGCD; i++) begin : g_gcd
		mi_gcd_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.in_vld(gcd_vld[i]), .in_d(gcd_d[i]),
			.out_vld(gcd_vld[i+1]), .out_d(gcd_d[i+1])
		);
	end

	// The coefficient of the value is folded into range by adding n at most twice, then subtracting n at most twice.
	// The halving steps drop common factors of two, so two even operands are
	// caught directly.
	always_comb begin
		fin = gcd_d[NGCD];
		ns = $signed({{(CW-WIDTH){1'b0}}, fin.n});
		t1 = (fin.cc < 0) ? fin.cc + ns : fin.cc;
		t2 = (t1 < 0) ? t1 + ns : t1;
		t3 = (t2 >= ns) ? t2 - ns : t2;
		t4 = (t3 >= ns) ? t3 - ns : t3;
		if (fin.n == '0) begin
			inv_nxt = '0;
			bad_nxt = 1'b1;
		end else if (fin.n == {{(WIDTH-1){1'b0}}, 1'b1}) begin
			inv_nxt = {{(WIDTH-1){1'b0}}, 1'b1};
			bad_nxt = 1'b0;
		end else if (fin.u != '0 || fin.v != {{(WIDTH-1){1'b0}}, 1'b1}
				|| (!fin.x[0] && !fin.n[0])) begin
			inv_nxt = '0;
			bad_nxt = 1'b1;
		end else begin
			inv_nxt = t4[WIDTH-1:0];
			bad_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= gcd_vld[NGCD];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_q <= inv_nxt;
			bad_q <= bad_nxt;
			n_out_q <= fin.n;
		end
	end

	assign result_valid = out_vld_q;
	assign inverse = inv_q;
	assign not_unit = bad_q;

	`ASSERT_NEVER(a_bad_nonzero, clk, arst_n, out_vld_q && bad_q && inv_q != '0)
	`ASSERT_NEVER(a_inv_range, clk, arst_n,
		out_vld_q && !bad_q && inv_q >= n_out_q && n_out_q != {{(WIDTH-1){1'b0}}, 1'b1})
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, value_stall |-> (out_vld_q && result_stall))
	`ASSERT_IMPL(a_hold_result, clk, arst_n, (out_vld_q && result_stall) |=> out_vld_q)
endmodule
